### src/icmpchk_pkg.sv
// Package for the ICMP echo reply checker: constants, types and the
// ones-complement add used by the per-byte datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmpchk_pkg;

    // longest datagram taken; longer ones are rejected
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    // compare width: wide enough for a 16-bit length field and any count
    localparam int CMP_W = 17;

    // protocol constants
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam int          IP_HDR_MIN    = 20;
    localparam int          ICMP_HDR_LEN  = 8;
    localparam int          MIN_DGRAM_LEN = IP_HDR_MIN + ICMP_HDR_LEN;
    localparam logic [15:0] FRAG_DF       = 16'h4000;
    localparam logic [7:0]  FRAG_HI_MASK  = ~FRAG_DF[15:8];
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [15:0] SUM_OK        = 16'hffff;

    // IP header byte positions
    localparam int POS_VER_IHL = 0;
    localparam int POS_TLEN_HI = 2;
    localparam int POS_TLEN_LO = 3;
    localparam int POS_FRAG_HI = 6;
    localparam int POS_FRAG_LO = 7;
    localparam int POS_PROTO   = 9;
    localparam int POS_SRC_LO  = 12;
    localparam int POS_SRC_HI  = 15;

    // ICMP header byte offsets
    localparam int ICMP_TYPE   = 0;
    localparam int ICMP_CODE   = 1;
    localparam int ICMP_ID_HI  = 4;
    localparam int ICMP_ID_LO  = 5;
    localparam int ICMP_SEQ_HI = 6;
    localparam int ICMP_SEQ_LO = 7;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GATEWAY = 2'd0,
        CFG_IDENT   = 2'd1,
        CFG_SEQ     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] gateway;
        logic [15:0] ident;
        logic [15:0] seq;
    } t_cfg_regs;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

`default_nettype wire

### src/icmp_echo_reply_checker.sv
// Top level of the ICMP echo reply checker: input register, config
// registers, result register. Depends on icmpchk_pkg and icmpchk_core.
`timescale 1ns / 1ps
`default_nettype none

// Checks a received IPv4 datagram, one byte per item with a last-byte marker,
// and gives one result item at the last byte: 1 if it is a valid ICMP echo
// reply (both checksums good, lengths consistent, no fragmentation) from the
// configured gateway with the configured identifier and sequence. Each byte sits
// in the input register while the per-byte checks and a 16-bit ones-complement
// add update the datagram state, and the verdict is registered in the result
// register as the last byte moves on, so the block takes a byte in every cycle.
// Only a last byte can wait, when the result register still holds an untaken
// verdict. Datagrams over MAX_PACKET_BYTES give 0.
// Configuration registers are written through the cfg channel, always ready.
module icmp_echo_reply_checker
    import icmpchk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // verdict items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_reply_match,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_vld;
    logic       r_out_match;
    t_cfg_regs  r_cfg;
    logic       adv;
    logic       core_match;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GATEWAY: r_cfg.gateway <= i_cfg_data;
                CFG_IDENT:   r_cfg.ident   <= i_cfg_data[15:0];
                CFG_SEQ:     r_cfg.seq     <= i_cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // a byte moves on unless it is a last byte facing a full result register whose verdict is not taken
    assign adv        = r_in_vld && (!r_in_last || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // per-byte datapath
    icmpchk_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_match (core_match)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_match <= core_match;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_reply_match = r_out_match;

    // a non-last byte is never held back
    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_in_last) |-> !o_in_stall)
        else $error("non-last byte stalled");

    // a last byte that moves on leaves a verdict in the result register
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> o_out_valid)
        else $error("last byte gave no result");

    // input stall only with a waiting last byte and a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_in_last && r_out_vld && i_out_stall))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

### src/icmpchk_core.sv
// Per-byte datagram state: field checks, running checksums, final verdict.
// Depends on icmpchk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmpchk_core
    import icmpchk_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic      i_last,
    input  wire t_cfg_regs i_cfg,
    output logic           o_match
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [5:0]       r_hdr_bytes, n_hdr_bytes;
    logic [15:0]      r_tot_len, n_tot_len;
    logic [15:0]      r_hdr_sum, n_hdr_sum;
    logic [15:0]      r_pay_sum, n_pay_sum;
    logic [7:0]       r_held, n_held;
    logic             r_reject, n_reject;

    logic [5:0]       hb_eff;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] k;
    logic [15:0]      pad_sum;
    logic [15:0]      fin_sum;

    // per-byte checks and state update
    always_comb begin
        n_pos       = r_pos;
        n_hdr_bytes = r_hdr_bytes;
        n_tot_len   = r_tot_len;
        n_hdr_sum   = r_hdr_sum;
        n_pay_sum   = r_pay_sum;
        n_held      = r_held;
        n_reject    = r_reject;
        hb_eff      = r_hdr_bytes;
        pos_c       = CMP_W'(r_pos);
        k           = '0;

        if (r_pos >= POS_W'(MAX_PACKET_BYTES)) begin
            n_reject = 1'b1;
        end else begin
            // fixed IP header fields
            if (pos_c == CMP_W'(POS_VER_IHL)) begin
                if (i_byte[7:4] != IP_VERSION) n_reject = 1'b1;
                hb_eff      = {i_byte[3:0], 2'b00};
                n_hdr_bytes = hb_eff;
                if (hb_eff < 6'(IP_HDR_MIN)) n_reject = 1'b1;
            end else if (pos_c == CMP_W'(POS_TLEN_HI)) begin
                n_tot_len = {i_byte, 8'h00};
            end else if (pos_c == CMP_W'(POS_TLEN_LO)) begin
                n_tot_len = {r_tot_len[15:8], i_byte};
            end else if (pos_c == CMP_W'(POS_FRAG_HI)) begin
                if ((i_byte & FRAG_HI_MASK) != 8'h00) n_reject = 1'b1;
            end else if (pos_c == CMP_W'(POS_FRAG_LO)) begin
                if (i_byte != 8'h00) n_reject = 1'b1;
            end else if (pos_c == CMP_W'(POS_PROTO)) begin
                if (i_byte != PROTO_ICMP) n_reject = 1'b1;
            end else if (pos_c >= CMP_W'(POS_SRC_LO) && pos_c <= CMP_W'(POS_SRC_HI)) begin
                case (r_pos[1:0])
                    2'd0:    if (i_cfg.gateway[31:24] != i_byte) n_reject = 1'b1;
                    2'd1:    if (i_cfg.gateway[23:16] != i_byte) n_reject = 1'b1;
                    2'd2:    if (i_cfg.gateway[15:8]  != i_byte) n_reject = 1'b1;
                    default: if (i_cfg.gateway[7:0]   != i_byte) n_reject = 1'b1;
                endcase
            end

            // ICMP header fields, relative to the end of the IP header
            if (pos_c >= CMP_W'(hb_eff)) begin
                k = pos_c - CMP_W'(hb_eff);
                if (k == CMP_W'(ICMP_TYPE) || k == CMP_W'(ICMP_CODE)) begin
                    if (i_byte != 8'h00) n_reject = 1'b1;
                end else if (k == CMP_W'(ICMP_ID_HI)) begin
                    if (i_cfg.ident[15:8] != i_byte) n_reject = 1'b1;
                end else if (k == CMP_W'(ICMP_ID_LO)) begin
                    if (i_cfg.ident[7:0] != i_byte) n_reject = 1'b1;
                end else if (k == CMP_W'(ICMP_SEQ_HI)) begin
                    if (i_cfg.seq[15:8] != i_byte) n_reject = 1'b1;
                end else if (k == CMP_W'(ICMP_SEQ_LO)) begin
                    if (i_cfg.seq[7:0] != i_byte) n_reject = 1'b1;
                end
            end

            // running checksums, one 16-bit word per byte pair
            if (!r_pos[0]) begin
                n_held = i_byte;
            end else if (pos_c < CMP_W'(hb_eff)) begin
                n_hdr_sum = oc_add(r_hdr_sum, {r_held, i_byte});
            end else begin
                n_pay_sum = oc_add(r_pay_sum, {r_held, i_byte});
            end

            n_pos = r_pos + POS_W'(1);
        end
    end

    // verdict at the last byte; odd byte count pads the held byte with zero
    always_comb begin
        pad_sum = oc_add(n_pay_sum, {n_held, 8'h00});
        fin_sum = n_pos[0] ? pad_sum : n_pay_sum;
        o_match = !n_reject
               && (CMP_W'(n_pos) >= CMP_W'(MIN_DGRAM_LEN))
               && (CMP_W'(n_pos) >= CMP_W'(n_hdr_bytes) + CMP_W'(ICMP_HDR_LEN))
               && (CMP_W'(n_pos) == CMP_W'(n_tot_len))
               && (n_hdr_sum == SUM_OK)
               && (fin_sum == SUM_OK);
    end

    // datagram state, cleared after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos       <= '0;
            r_hdr_bytes <= '0;
            r_tot_len   <= '0;
            r_hdr_sum   <= '0;
            r_pay_sum   <= '0;
            r_held      <= '0;
            r_reject    <= 1'b0;
        end else if (i_take) begin
            r_pos       <= n_pos;
            r_hdr_bytes <= n_hdr_bytes;
            r_tot_len   <= n_tot_len;
            r_hdr_sum   <= n_hdr_sum;
            r_pay_sum   <= n_pay_sum;
            r_held      <= n_held;
            r_reject    <= n_reject;
        end
    end

endmodule

`default_nettype wire
